FILE: hw/rtl/obk_pkg.sv
// shared types and constants for the order book level tracker
// no dependencies

package obk_pkg;

    localparam int PW        = 31;
    localparam int ROWS      = 20;
    localparam int HALF_ROWS = 10;
    localparam int RW        = 5;

    typedef logic [PW-1:0] t_price;
    typedef logic [RW-1:0] t_row;

    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_LEVEL = 2'd2;

    // result of the shared price comparator
    typedef struct packed {
        logic eq;
        logic beats;
    } t_cmp;

endpackage

FILE: hw/rtl/obk_cmp.sv
// shared price comparator: equality and side-aware "beats"
// depends on obk_pkg

module obk_cmp (
    input  obk_pkg::t_price i_a,
    input  obk_pkg::t_price i_b,
    input  logic            i_ask,
    output obk_pkg::t_cmp   o_cmp
);
    import obk_pkg::*;

    // bids: higher beats, asks: lower beats
    always_comb begin
        o_cmp.eq    = (i_a == i_b);
        o_cmp.beats = i_ask ? (i_a < i_b) : (i_a > i_b);
    end

endmodule

FILE: hw/rtl/order_book_level_tracker_unit.sv
// order book level tracker: bid/ask level lists, tick and snapshot merge
// depends on obk_pkg and obk_cmp
//
// channel | direction | signals
// --------+-----------+--------------------------------------------------
// in      | slave     | i_in_valid / o_in_ready, command and level fields
// out     | master    | o_out_valid / i_out_ready, one display row a word
//
// a reset or tick/snapshot end item is followed by 20 output words, one per
// cycle when the sink keeps ready high; all book work runs through one
// comparator, one price pair a cycle: a tick scans each side for its price,
// drops the levels in front of it or inserts it at the front; a snapshot
// end runs the compare, merge and removal scans on each side
// the input is not ready while a command is processed; a plain snapshot
// level is accepted in idle; the last word may still wait in the output
// register while the next item is accepted
// reset clears counts, flags, sequencer state and output valid

module order_book_level_tracker_unit #(
    parameter int DEPTH = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_cmd,
    input  logic            i_side,
    input  obk_pkg::t_price i_level_price,
    input  obk_pkg::t_price i_level_volume,
    input  logic            i_snapshot_end,
    input  obk_pkg::t_price i_tick_bid_price,
    input  obk_pkg::t_price i_tick_ask_price,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output obk_pkg::t_row   o_row,
    output obk_pkg::t_price o_row_price,
    output obk_pkg::t_price o_row_volume,
    output logic            o_last_row
);
    import obk_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TICK = 4'd1;
    localparam logic [3:0] S_DROP = 4'd2;
    localparam logic [3:0] S_SAME = 4'd3;
    localparam logic [3:0] S_COPY = 4'd4;
    localparam logic [3:0] S_MI   = 4'd5;
    localparam logic [3:0] S_MJ   = 4'd6;
    localparam logic [3:0] S_RM   = 4'd7;
    localparam logic [3:0] S_RI   = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    // books and staged lists, index 0 bid, 1 ask
    t_price          r_p  [2][DEPTH], n_p  [2][DEPTH];
    t_price          r_v  [2][DEPTH], n_v  [2][DEPTH];
    logic [CW-1:0]   r_n  [2],        n_n  [2];
    t_price          r_sp [2][DEPTH], n_sp [2][DEPTH];
    t_price          r_sv [2][DEPTH], n_sv [2][DEPTH];
    logic [CW-1:0]   r_sn [2],        n_sn [2];
    logic            r_seen, n_seen;

    // sequencer
    logic [3:0]      r_state, n_state;
    logic            r_side, n_side;
    logic            r_merge, n_merge;
    logic [CW-1:0]   r_i, n_i, r_j, n_j, r_at, n_at, r_w, n_w;
    logic            r_same, n_same, r_found, n_found, r_keep, n_keep;
    t_price          r_tb, n_tb, r_ta, n_ta;
    t_row            r_row, n_row;

    // output word register
    logic            r_ovalid, n_ovalid;
    t_row            r_orow, n_orow;
    t_price          r_oprice, n_oprice, r_ovol, n_ovol;
    logic            r_olast, n_olast;

    // book read port, one address a cycle
    logic            w_rd_side;
    logic [IW-1:0]   w_rd_idx;
    t_price          w_bk_p, w_bk_v;
    logic [4:0]      w_eidx;
    logic            w_evalid;
    t_price          w_sp, w_sv, w_cmp_a;
    t_cmp            w_cmp;

    always_comb begin
        if (r_row < t_row'(HALF_ROWS)) begin
            w_eidx = 5'(HALF_ROWS - 1) - r_row;
        end else begin
            w_eidx = r_row - 5'(HALF_ROWS);
        end
    end

    assign w_evalid = (6'(w_eidx) < 6'(r_n[r_row < t_row'(HALF_ROWS)]))
                   && (6'(w_eidx) < 6'(DEPTH));

    always_comb begin
        w_rd_side = r_side;
        w_rd_idx  = r_j[IW-1:0];
        if (r_state == S_EMIT) begin
            w_rd_side = (r_row < t_row'(HALF_ROWS));
            w_rd_idx  = w_evalid ? IW'(w_eidx) : '0;
        end else if (r_state == S_SAME || r_state == S_COPY) begin
            w_rd_idx  = r_i[IW-1:0];
        end
    end

    assign w_bk_p  = r_p[w_rd_side][w_rd_idx];
    assign w_bk_v  = r_v[w_rd_side][w_rd_idx];
    assign w_sp    = r_sp[r_side][r_i[IW-1:0]];
    assign w_sv    = r_sv[r_side][r_i[IW-1:0]];
    assign w_cmp_a = (r_state == S_TICK) ? (r_side ? r_ta : r_tb) : w_sp;

    obk_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_bk_p),
        .i_ask (r_side),
        .o_cmp (w_cmp)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_row        = r_orow;
    assign o_row_price  = r_oprice;
    assign o_row_volume = r_ovol;
    assign o_last_row   = r_olast;

    always_comb begin
        logic          done_side;
        logic          ins_do;
        logic [CW-1:0] ins_at;
        t_price        ins_price, ins_vol;
        logic          drop_do;

        n_p = r_p;  n_v = r_v;  n_n = r_n;
        n_sp = r_sp; n_sv = r_sv; n_sn = r_sn;
        n_seen = r_seen;
        n_state = r_state; n_side = r_side; n_merge = r_merge;
        n_i = r_i; n_j = r_j; n_at = r_at; n_w = r_w;
        n_same = r_same; n_found = r_found; n_keep = r_keep;
        n_tb = r_tb; n_ta = r_ta; n_row = r_row;
        n_ovalid = r_ovalid; n_orow = r_orow; n_oprice = r_oprice;
        n_ovol = r_ovol; n_olast = r_olast;
        done_side = 1'b0;
        ins_do = 1'b0; ins_at = '0; ins_price = '0; ins_vol = '0;
        drop_do = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_side = 1'b0;
                    n_row  = '0;
                    n_tb   = i_tick_bid_price;
                    n_ta   = i_tick_ask_price;
                    if (i_cmd == CMD_RESET) begin
                        n_n[0] = '0; n_n[1] = '0;
                        n_sn[0] = '0; n_sn[1] = '0;
                        n_seen = 1'b0;
                        n_state = S_EMIT;
                    end else if (i_cmd == CMD_TICK) begin
                        n_merge = 1'b0;
                        n_j = '0;
                        if (!r_seen) begin
                            n_p[0][0] = i_tick_bid_price; n_v[0][0] = '0;
                            n_p[1][0] = i_tick_ask_price; n_v[1][0] = '0;
                            n_n[0] = CW'(1); n_n[1] = CW'(1);
                            n_state = S_EMIT;
                        end else if (r_n[0] != '0 && r_n[1] != '0) begin
                            n_state = S_TICK;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else if (i_cmd == CMD_LEVEL) begin
                        // append to staged list, levels past depth dropped
                        if (r_sn[i_side] < CW'(DEPTH)) begin
                            n_sp[i_side][r_sn[i_side][IW-1:0]] = i_level_price;
                            n_sv[i_side][r_sn[i_side][IW-1:0]] = i_level_volume;
                            n_sn[i_side] = r_sn[i_side] + CW'(1);
                        end
                        if (i_snapshot_end) begin
                            n_seen  = 1'b1;
                            n_merge = 1'b1;
                            n_i     = '0;
                            n_same  = (n_sn[0] == r_n[0]);
                            n_state = S_SAME;
                        end
                    end
                end
            end
            S_TICK: begin
                if (r_j == r_n[r_side]) begin
                    ins_do = 1'b1; ins_at = '0;
                    ins_price = r_side ? r_ta : r_tb;
                    done_side = 1'b1;
                end else if (w_cmp.eq) begin
                    if (r_j == '0) begin
                        done_side = 1'b1;
                    end else begin
                        n_at = r_j;
                        n_state = S_DROP;
                    end
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            S_DROP: begin
                // drop front levels one at a time
                drop_do = 1'b1;
                n_n[r_side] = r_n[r_side] - CW'(1);
                n_at = r_at - CW'(1);
                if (r_at == CW'(1)) begin
                    done_side = 1'b1;
                end
            end
            S_SAME: begin
                if (!r_same || r_i == r_sn[r_side]) begin
                    n_i = '0;
                    n_state = r_same ? S_COPY : S_MI;
                end else begin
                    if (!w_cmp.eq) begin
                        n_same = 1'b0;
                    end
                    n_i = r_i + CW'(1);
                end
            end
            S_COPY: begin
                if (r_i == r_sn[r_side]) begin
                    done_side = 1'b1;
                end else begin
                    n_v[r_side][r_i[IW-1:0]] = w_sv;
                    n_i = r_i + CW'(1);
                end
            end
            S_MI: begin
                if (r_i == r_sn[r_side]) begin
                    n_j = '0; n_w = '0;
                    n_state = S_RM;
                end else if (w_sp == '0) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = '0;
                    n_at = r_n[r_side];
                    n_found = 1'b0;
                    n_state = S_MJ;
                end
            end
            S_MJ: begin
                if (r_j == r_n[r_side]) begin
                    if (!r_found) begin
                        ins_do = 1'b1; ins_at = r_at;
                        ins_price = w_sp; ins_vol = w_sv;
                    end
                    n_i = r_i + CW'(1);
                    n_state = S_MI;
                end else begin
                    if (r_at == r_n[r_side] && w_cmp.beats) begin
                        n_at = r_j;
                    end
                    if (w_cmp.eq) begin
                        n_found = 1'b1;
                        n_v[r_side][r_j[IW-1:0]] = w_sv;
                    end
                    n_j = r_j + CW'(1);
                end
            end
            S_RM: begin
                if (r_j == r_n[r_side]) begin
                    n_n[r_side] = r_w;
                    done_side = 1'b1;
                end else begin
                    n_i = '0;
                    n_keep = 1'b0;
                    n_state = S_RI;
                end
            end
            S_RI: begin
                // keep level j only if its price is in the snapshot
                if (r_keep || r_i == r_sn[r_side]) begin
                    if (r_keep) begin
                        n_p[r_side][r_w[IW-1:0]] = w_bk_p;
                        n_v[r_side][r_w[IW-1:0]] = w_bk_v;
                        n_w = r_w + CW'(1);
                    end
                    n_j = r_j + CW'(1);
                    n_state = S_RM;
                end else begin
                    if (w_cmp.eq) begin
                        n_keep = 1'b1;
                    end
                    n_i = r_i + CW'(1);
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_orow   = r_row;
                    n_oprice = w_evalid ? w_bk_p : '0;
                    n_ovol   = w_evalid ? w_bk_v : '0;
                    n_olast  = (r_row == t_row'(ROWS - 1));
                    if (r_row == t_row'(ROWS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + t_row'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // insert at a position, deepest level falls off a full book
        if (ins_do && ins_at < CW'(DEPTH) && ins_at <= r_n[r_side]) begin
            for (int k = 1; k < DEPTH; k++) begin
                if (CW'(k) > ins_at) begin
                    n_p[r_side][k] = r_p[r_side][k-1];
                    n_v[r_side][k] = r_v[r_side][k-1];
                end
            end
            n_p[r_side][ins_at[IW-1:0]] = ins_price;
            n_v[r_side][ins_at[IW-1:0]] = ins_vol;
            if (r_n[r_side] < CW'(DEPTH)) begin
                n_n[r_side] = r_n[r_side] + CW'(1);
            end
        end

        if (drop_do) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                n_p[r_side][k] = r_p[r_side][k+1];
                n_v[r_side][k] = r_v[r_side][k+1];
            end
        end

        if (done_side) begin
            if (!r_side) begin
                n_side = 1'b1;
                n_i = '0;
                n_j = '0;
                n_same = (r_sn[1] == r_n[1]);
                n_state = r_merge ? S_SAME : S_TICK;
            end else begin
                if (r_merge) begin
                    n_sn[0] = '0;
                    n_sn[1] = '0;
                end
                n_row = '0;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= n_p;
        r_v  <= n_v;
        r_sp <= n_sp;
        r_sv <= n_sv;
        r_side <= n_side; r_merge <= n_merge;
        r_i <= n_i; r_j <= n_j; r_at <= n_at; r_w <= n_w;
        r_same <= n_same; r_found <= n_found; r_keep <= n_keep;
        r_tb <= n_tb; r_ta <= n_ta; r_row <= n_row;
        r_orow <= n_orow; r_oprice <= n_oprice; r_ovol <= n_ovol;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_n[0] <= '0; r_n[1] <= '0;
            r_sn[0] <= '0; r_sn[1] <= '0;
            r_seen <= 1'b0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_n <= n_n;
            r_sn <= n_sn;
            r_seen <= n_seen;
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
